// ----- design/eoq_pkg.sv -----
`default_nettype none
// ============================================================================
// eoq_pkg: shared types and constants for the elevator order queue
// Floor and command encodings, the command item and the default stop count.
// ============================================================================
package eoq_pkg;

    // Width of a floor number on the command and result channels.
    localparam int FLOOR_W = 2;

    // Default number of stop slots.
    localparam int NUM_FLOORS_DEF = 4;

    typedef logic [FLOOR_W-1:0] floor_t;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_SET_LAST = 2'd1,
        OP_POP      = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        BTN_UP   = 2'd0,
        BTN_DOWN = 2'd1,
        BTN_CAB  = 2'd2,
        BTN_ANY  = 2'd3
    } button_t;

    typedef struct packed {
        op_t     op;
        floor_t  current_floor;
        floor_t  requested_floor;
        button_t button;
    } item_t;

endpackage
`default_nettype wire

// ----- design/eoq_if.sv -----
`default_nettype none
// ============================================================================
// eoq_if: command and result channel interfaces
// Valid/ready channels; a transaction completes when valid and ready are high.
// ============================================================================
interface eoq_cmd_if
    import eoq_pkg::*;
;
    logic   valid;
    logic   ready;
    logic [1:0] op;
    floor_t current_floor;
    floor_t requested_floor;
    logic [1:0] button;

    modport source (output valid, output op, output current_floor,
                    output requested_floor, output button, input ready);
    modport sink   (input valid, input op, input current_floor,
                    input requested_floor, input button, output ready);
endinterface

interface eoq_rsp_if
    import eoq_pkg::*;
;
    logic   valid;
    logic   ready;
    floor_t head_floor;
    logic   list_empty;

    modport source (output valid, output head_floor, output list_empty, input ready);
    modport sink   (input valid, input head_floor, input list_empty, output ready);
endinterface
`default_nettype wire

// ----- design/eoq_list_logic.sv -----
`default_nettype none
// ============================================================================
// eoq_list_logic: next-state logic of the stop list
// Applies one command to the last floor and the packed list of stops.
// ============================================================================
module eoq_list_logic
    import eoq_pkg::*;
#(
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
)
(
    input  item_t                 item,
    input  logic                  last_vld,
    input  floor_t                last_floor,
    input  logic [NUM_FLOORS-1:0] slot_vld,
    input  floor_t                slot_floor [NUM_FLOORS],
    output logic                  last_vld_next,
    output floor_t                last_floor_next,
    output logic [NUM_FLOORS-1:0] slot_vld_next,
    output floor_t                slot_floor_next [NUM_FLOORS]
);

    always_comb
    begin
        logic   [NUM_FLOORS-1:0] pa_vld;
        floor_t                  pa_floor [NUM_FLOORS];
        logic   [NUM_FLOORS-1:0] hit;
        logic   [NUM_FLOORS-1:0] ins;
        logic   [NUM_FLOORS-1:0] stop;
        logic   [NUM_FLOORS-1:0] pick;
        logic   [NUM_FLOORS-1:0] at_or_after_pick;
        logic   [NUM_FLOORS-1:0] after_copy;
        logic                    dest_gt_a;
        logic                    dest_lt_a;
        logic                    going_up;
        logic                    between;
        logic                    dir_ok;
        logic                    drop;
        floor_t                  dest;

        last_vld_next   = last_vld;
        last_floor_next = last_floor;
        slot_vld_next   = slot_vld;
        slot_floor_next = slot_floor;
        dest            = item.requested_floor;

        // Path points: the last sensed floor, then each stop in turn.
        pa_vld[0]   = last_vld;
        pa_floor[0] = last_floor;
        for (int i = 1; i < NUM_FLOORS; i++)
        begin
            pa_vld[i]   = slot_vld[i-1];
            pa_floor[i] = slot_floor[i-1];
        end

        // An unknown path point sits below every floor.
        for (int k = 0; k < NUM_FLOORS; k++)
        begin
            dest_gt_a = !pa_vld[k] || (dest > pa_floor[k]);
            dest_lt_a = pa_vld[k] && (dest < pa_floor[k]);
            going_up  = !pa_vld[k] || (slot_floor[k] > pa_floor[k]);
            between   = slot_vld[k] && ((dest_gt_a && dest < slot_floor[k]) ||
                                        (dest_lt_a && dest > slot_floor[k]));
            unique case (item.button)
                BTN_UP:   dir_ok = going_up;
                BTN_DOWN: dir_ok = !going_up;
                default:  dir_ok = 1'b1;
            endcase
            hit[k]  = slot_vld[k] && (slot_floor[k] == dest);
            ins[k]  = between && dir_ok;
            stop[k] = hit[k] || !slot_vld[k] || ins[k];
        end

        pick             = stop & (~stop + 1'b1);
        at_or_after_pick = ~(pick - 1'b1);
        // Slots past the stored copy of the floor keep their place on insertion.
        after_copy       = ~((hit << 1) - 1'b1);

        // The car standing at the requested floor with an empty list still books it.
        drop = !(!slot_vld[0] && dest == item.current_floor) &&
               last_vld && dest == last_floor && last_floor == item.current_floor;

        unique case (item.op)
            OP_ADD:
            begin
                if (!drop && (pick & hit) == '0)
                begin
                    if ((pick & ~slot_vld) != '0)
                    begin
                        for (int i = 0; i < NUM_FLOORS; i++)
                        begin
                            if (pick[i])
                            begin
                                slot_vld_next[i]   = 1'b1;
                                slot_floor_next[i] = dest;
                            end
                        end
                    end
                    else if (pick != '0)
                    begin
                        for (int i = 1; i < NUM_FLOORS; i++)
                        begin
                            if (at_or_after_pick[i] && !pick[i] && !after_copy[i])
                            begin
                                slot_vld_next[i]   = slot_vld[i-1];
                                slot_floor_next[i] = slot_floor[i-1];
                            end
                        end
                        for (int i = 0; i < NUM_FLOORS; i++)
                        begin
                            if (pick[i])
                            begin
                                slot_vld_next[i]   = 1'b1;
                                slot_floor_next[i] = dest;
                            end
                        end
                    end
                end
            end
            OP_SET_LAST:
            begin
                last_vld_next   = 1'b1;
                last_floor_next = item.current_floor;
            end
            OP_POP:
            begin
                for (int i = 0; i < NUM_FLOORS - 1; i++)
                begin
                    slot_vld_next[i]   = slot_vld[i+1];
                    slot_floor_next[i] = slot_floor[i+1];
                end
                slot_vld_next[NUM_FLOORS-1] = 1'b0;
            end
            OP_CLEAR:
            begin
                slot_vld_next = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/elevator_order_queue_unit.sv -----
`default_nettype none
// A command waits in the command register; its result waits in the result register.
// Throughput: one command per cycle while results are taken; the list update is a
// single pass of logic between the command register and the result register.
// Reset clears the stop list and the last floor and empties both stages;
// no clearing pass is needed, commands are taken right after reset.
// ============================================================================
// elevator_order_queue_unit: elevator stop-order list
// Keeps the last sensed floor and an ordered list of stops, and reports
// the head stop and an empty flag after every command.
// ============================================================================
module elevator_order_queue_unit
    import eoq_pkg::*;
#(
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    eoq_cmd_if.sink   cmd,
    eoq_rsp_if.source rsp
);

    logic                  s1_vld_reg;
    item_t                 s1_item_reg;
    logic                  last_vld_reg;
    floor_t                last_floor_reg;
    logic [NUM_FLOORS-1:0] slot_vld_reg;
    floor_t                slot_floor_reg [NUM_FLOORS];
    logic                  out_vld_reg;
    floor_t                out_head_reg;
    logic                  out_empty_reg;

    logic                  last_vld_next;
    floor_t                last_floor_next;
    logic [NUM_FLOORS-1:0] slot_vld_next;
    floor_t                slot_floor_next [NUM_FLOORS];

    logic                  out_free;
    logic                  proc;
    logic                  cmd_take;

    assign out_free  = !out_vld_reg || rsp.ready;
    assign proc      = s1_vld_reg && out_free;
    assign cmd.ready = !s1_vld_reg || out_free;
    assign cmd_take  = cmd.valid && cmd.ready;

    eoq_list_logic #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_list (
        .item            (s1_item_reg),
        .last_vld        (last_vld_reg),
        .last_floor      (last_floor_reg),
        .slot_vld        (slot_vld_reg),
        .slot_floor      (slot_floor_reg),
        .last_vld_next   (last_vld_next),
        .last_floor_next (last_floor_next),
        .slot_vld_next   (slot_vld_next),
        .slot_floor_next (slot_floor_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            last_vld_reg <= 1'b0;
            slot_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (proc)
            begin
                s1_vld_reg <= 1'b0;
            end

            if (proc)
            begin
                last_vld_reg <= last_vld_next;
                slot_vld_reg <= slot_vld_next;
                out_vld_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_item_reg.op              <= op_t'(cmd.op);
            s1_item_reg.current_floor   <= cmd.current_floor;
            s1_item_reg.requested_floor <= cmd.requested_floor;
            s1_item_reg.button          <= button_t'(cmd.button);
        end
        if (proc)
        begin
            last_floor_reg <= last_floor_next;
            slot_floor_reg <= slot_floor_next;
            out_empty_reg  <= !slot_vld_next[0];
            out_head_reg   <= slot_vld_next[0] ? slot_floor_next[0] : '0;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.head_floor = out_head_reg;
    assign rsp.list_empty = out_empty_reg;

`ifndef NO_ASSERTIONS
    // Stored stops always sit packed at the front of the list.
    a_slots_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_vld_reg & (slot_vld_reg + 1'b1)) == '0)
        else $error("stop list is not packed");

    // Once known, the last floor is never forgotten.
    a_last_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(last_vld_reg))
        else $error("last floor lost");

    // A processed command always yields a pending result.
    a_proc_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_vld_reg)
        else $error("processed command produced no result");

    // A held command stays put while the result register is blocked.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !out_free) |=> (s1_vld_reg && $stable(s1_item_reg)))
        else $error("command register changed while stalled");
`endif

endmodule
`default_nettype wire

// ----- test/elevator_order_queue_checker.sv -----
// ============================================================================
// elevator_order_queue_checker: stop-list predictor and result comparator
// Watches the command and result channels, keeps its own copy of the last
// floor and the stop list, and compares every result with the oldest status
// still awaited.
// ============================================================================
module elevator_order_queue_checker
    import eoq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    eoq_cmd_if   cmd,
    eoq_rsp_if   rsp,
    output int   mismatches,
    output int   awaiting,
    output int   results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = NUM_FLOORS_DEF;

    // Floors plus the "no floor" marker need one sign bit.
    typedef logic signed [2:0] slot_t;
    localparam slot_t NO_FLOOR = -3'sd2;

    typedef struct packed {
        floor_t head_floor;
        logic   list_empty;
    } status_t;

    slot_t   model_last;
    slot_t   model_stops [NSLOT];
    status_t awaited_status [$];

    function automatic void clear_stops();
        for (int i = 0; i < NSLOT; i++)
        begin
            model_stops[i] = NO_FLOOR;
        end
    endfunction

    function automatic void add_stop(slot_t car, slot_t dest, button_t btn);
        slot_t a;
        slot_t b;
        slot_t kept [NSLOT];
        int    w;
        if (model_stops[0] == NO_FLOOR && dest == car)
        begin
            model_stops[0] = dest;
            return;
        end
        if (dest == model_last && model_last == car)
        begin
            return;
        end
        for (int k = 0; k < NSLOT; k++)
        begin
            a = (k == 0) ? model_last : model_stops[k-1];
            b = model_stops[k];
            if (dest == b)
            begin
                return;
            end
            if (b == NO_FLOOR)
            begin
                model_stops[k] = dest;
                return;
            end
            if ((dest > a && dest < b) || (dest < a && dest > b))
            begin
                // Hall calls only ride along on a segment that travels their way.
                if ((btn == BTN_UP && !(b > a)) || (btn == BTN_DOWN && (b > a)))
                begin
                    continue;
                end
                w = 0;
                for (int r = 0; r < NSLOT; r++)
                begin
                    if (model_stops[r] != dest)
                    begin
                        kept[w] = model_stops[r];
                        w++;
                    end
                end
                for (; w < NSLOT; w++)
                begin
                    kept[w] = NO_FLOOR;
                end
                for (int r = NSLOT - 1; r > k; r--)
                begin
                    kept[r] = kept[r-1];
                end
                kept[k] = dest;
                model_stops = kept;
                return;
            end
        end
    endfunction

    function automatic status_t apply_command(op_t op, floor_t car, floor_t dest,
                                              button_t btn);
        status_t st;
        case (op)
            OP_ADD:
            begin
                add_stop(slot_t'({1'b0, car}), slot_t'({1'b0, dest}), btn);
            end
            OP_SET_LAST:
            begin
                model_last = slot_t'({1'b0, car});
            end
            OP_POP:
            begin
                for (int i = 0; i < NSLOT - 1; i++)
                begin
                    model_stops[i] = model_stops[i+1];
                end
                model_stops[NSLOT-1] = NO_FLOOR;
            end
            default:
            begin
                clear_stops();
            end
        endcase
        if (model_stops[0] == NO_FLOOR)
        begin
            st.head_floor = '0;
            st.list_empty = 1'b1;
        end
        else
        begin
            st.head_floor = floor_t'(model_stops[0][1:0]);
            st.list_empty = 1'b0;
        end
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        status_t want;
        if (!rst_n)
        begin
            model_last = NO_FLOOR;
            clear_stops();
            awaited_status.delete();
            mismatches = 0;
            awaiting = 0;
            results_checked = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                awaited_status.push_back(apply_command(op_t'(cmd.op), cmd.current_floor,
                                                       cmd.requested_floor,
                                                       button_t'(cmd.button)));
            end
            if (rsp.valid && rsp.ready)
            begin
                results_checked++;
                if (awaited_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result with nothing awaited: head %0d empty %0d",
                                 $time, rsp.head_floor, rsp.list_empty);
                    end
                end
                else
                begin
                    want = awaited_status.pop_front();
                    if (rsp.head_floor != want.head_floor
                        || rsp.list_empty != want.list_empty)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: status mismatch: head %0d/%0d empty %0d/%0d %s",
                                     $time, want.head_floor, rsp.head_floor,
                                     want.list_empty, rsp.list_empty,
                                     "(expected/actual)");
                        end
                    end
                end
            end
            awaiting = awaited_status.size();
        end
    end

endmodule

// ----- test/elevator_order_queue_unit_test.sv -----
// ============================================================================
// elevator_order_queue_unit_test: testbench for the elevator order queue
// A directed pass walks the insertion, drop and pop corner cases, then random
// commands run with random idling, a long result hold-off and full drains.
// ============================================================================
module elevator_order_queue_unit_test
    import eoq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 750;
    localparam int HOLD_AT      = 900;
    localparam int DRAIN_AT     = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;

    logic   clk = 1'b0;
    logic   rst_n;
    int     mismatches;
    int     awaiting;
    int     results_checked;
    bit     calm = 1'b0;
    int     holdoffs_asked = 0;
    int     holdoffs_done = 0;
    int     op_count [4] = '{0, 0, 0, 0};
    int     quiet_cycles = 0;
    floor_t car_at = '0;

    eoq_cmd_if cmd_if ();
    eoq_rsp_if rsp_if ();

    elevator_order_queue_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    elevator_order_queue_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_if),
        .rsp             (rsp_if),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked)
    );

    always #5 clk = ~clk;

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_cmd(op_t op, floor_t car, floor_t dest, button_t btn);
        while (!calm && $urandom_range(99) < 33)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid           <= 1'b1;
        cmd_if.op              <= op;
        cmd_if.current_floor   <= car;
        cmd_if.requested_floor <= dest;
        cmd_if.button          <= btn;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        op_count[op]++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Result side: random stalls, a calm stretch, and hold-offs on request.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoffs_asked > holdoffs_done)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holdoffs_done++;
            end
            else if (calm)
            begin
                rsp_if.ready <= 1'b1;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= 33);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles.", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int      r;
        op_t     op;
        floor_t  car;
        floor_t  dest;
        button_t btn;

        rst_n                  = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.op              = OP_ADD;
        cmd_if.current_floor   = '0;
        cmd_if.requested_floor = '0;
        cmd_if.button          = BTN_UP;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Empty list, unknown last floor.
        send_cmd(OP_POP,      2'd0, 2'd0, BTN_UP);
        send_cmd(OP_CLEAR,    2'd3, 2'd3, BTN_ANY);
        send_cmd(OP_ADD,      2'd3, 2'd3, BTN_CAB);
        send_cmd(OP_ADD,      2'd0, 2'd1, BTN_UP);
        send_cmd(OP_ADD,      2'd0, 2'd0, BTN_DOWN);
        send_cmd(OP_ADD,      2'd0, 2'd2, BTN_CAB);
        // Inserting at the front removes the later copy of the same floor.
        send_cmd(OP_ADD,      2'd1, 2'd0, BTN_UP);
        send_cmd(OP_ADD,      2'd2, 2'd3, BTN_ANY);
        send_cmd(OP_POP,      2'd1, 2'd2, BTN_CAB);
        // Clearing keeps the last floor.
        send_cmd(OP_SET_LAST, 2'd3, 2'd0, BTN_DOWN);
        send_cmd(OP_CLEAR,    2'd0, 2'd1, BTN_UP);
        send_cmd(OP_ADD,      2'd2, 2'd0, BTN_DOWN);
        send_cmd(OP_ADD,      2'd2, 2'd1, BTN_DOWN);
        // Car standing at the last floor asks for that floor: dropped.
        send_cmd(OP_ADD,      2'd3, 2'd3, BTN_UP);
        send_cmd(OP_ADD,      2'd0, 2'd2, BTN_UP);
        send_cmd(OP_ADD,      2'd1, 2'd3, BTN_DOWN);
        send_cmd(OP_SET_LAST, 2'd0, 2'd3, BTN_ANY);
        send_cmd(OP_POP,      2'd3, 2'd1, BTN_DOWN);
        send_cmd(OP_ADD,      2'd0, 2'd1, BTN_UP);
        repeat (5) send_cmd(OP_POP, 2'd2, 2'd3, BTN_CAB);
        send_cmd(OP_CLEAR,    2'd1, 2'd2, BTN_DOWN);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if (n == HOLD_AT)
            begin
                holdoffs_asked++;
            end
            if (n == DRAIN_AT)
            begin
                drain_results();
            end
            r = $urandom_range(99);
            if (r < 50)
            begin
                op = OP_ADD;
            end
            else if (r < 70)
            begin
                op = OP_SET_LAST;
            end
            else if (r < 92)
            begin
                op = OP_POP;
            end
            else
            begin
                op = OP_CLEAR;
            end
            // Half the time the car stands where the floor sensor last saw it.
            car  = ($urandom_range(1) == 1) ? car_at : floor_t'($urandom_range(3));
            dest = floor_t'($urandom_range(3));
            btn  = button_t'($urandom_range(3));
            if (op == OP_SET_LAST)
            begin
                car_at = car;
            end
            send_cmd(op, car, dest, btn);
        end
        calm = 1'b0;
        drain_results();
        repeat (10) @(posedge clk);

        $display("Ran %0d commands: %0d adds, %0d floor updates, %0d pops, %0d clears.",
                 op_count[OP_ADD] + op_count[OP_SET_LAST] + op_count[OP_POP]
                 + op_count[OP_CLEAR], op_count[OP_ADD], op_count[OP_SET_LAST],
                 op_count[OP_POP], op_count[OP_CLEAR]);
        $display("Checked %0d results across random stalls, a %0d-cycle hold-off and drains.",
                 results_checked, HOLD_CYCLES);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/eoq_pkg.sv
design/eoq_if.sv
design/eoq_list_logic.sv
design/elevator_order_queue_unit.sv
test/elevator_order_queue_checker.sv
test/elevator_order_queue_unit_test.sv
